// ===== hw/rtl/inverse_distance_interpolator_unit_assert.svh =====
// assertion macros used by the interpolator sequencer
// no dependencies; included by idi_ctrl, which checks its own logic
`ifndef INVERSE_DISTANCE_INTERPOLATOR_UNIT_ASSERT_SVH
`define INVERSE_DISTANCE_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define IDI_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IDI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/idi_pkg.sv =====
// types and constants of the inverse distance interpolator
// no dependencies; imported by every module of the block
package idi_pkg;

	localparam logic        OP_WRITE = 1'b0;
	localparam logic        OP_QUERY = 1'b1;

	localparam logic [1:0]  SRC_EMPTY    = 2'd0;
	localparam logic [1:0]  SRC_SINGLE   = 2'd1;
	localparam logic [1:0]  SRC_EXACT    = 2'd2;
	localparam logic [1:0]  SRC_WEIGHTED = 2'd3;

	localparam logic [15:0] UNITY_FACTOR = 16'd4096;

	localparam int DIST_W = 24;
	localparam int WGT_W  = 33;

	typedef struct packed {
		logic signed [10:0] process;
		logic [10:0]        voltage;
		logic signed [8:0]  temperature;
		logic [15:0]        factor;
	} point_t;

	typedef struct packed {
		logic       write_en;
		logic       start_query;
		logic       sq_en;
		logic       sum_en;
		logic       div_start;
		logic       div_final;
		logic       mul_en;
		logic       acc_en;
		logic       ptr_inc;
		logic       set_src;
		logic [1:0] src;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_one;
		logic last_entry;
		logic dist_zero;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/idi_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on idi_pkg
module idi_div import idi_pkg::*; #(
	parameter int DVD_W = 53,
	parameter int DVS_W = 37,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [CNT_W-1:0] nbits,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             busy
);

	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, dq_q[DVD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
		end
	end

	assign quotient = dq_q;
	assign busy     = busy_q;

endmodule

// ===== hw/rtl/idi_datapath.sv =====
// point table, distance, weight and accumulation datapath
// depends on idi_pkg and idi_div
module idi_datapath import idi_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [3:0]                entry_index,
	input  logic signed [10:0]        process_hundredths,
	input  logic [10:0]               voltage_mv,
	input  logic signed [8:0]         temp_deg,
	input  logic [15:0]               delay_scale,
	input  logic                      cfg_write,
	input  logic [4:0]                entries_in_use,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [15:0]               factor_out,
	output logic [1:0]                source
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int AW    = (IDX_W > 4) ? IDX_W : 4;
	localparam int DEN_W = WGT_W + $clog2(TABLE_DEPTH);
	localparam int NUM_W = DEN_W + 16;
	localparam int DC_W  = $clog2(NUM_W + 1);

	point_t mem [TABLE_DEPTH];
	point_t rd_q;

	logic [4:0]           entries_q;
	logic [CW-1:0]        count;
	logic [IDX_W-1:0]     ptr_q;
	logic [AW-1:0]        wa;

	logic signed [10:0]   qp_q;
	logic [10:0]          qv_q;
	logic signed [8:0]    qt_q;

	logic signed [11:0]   dp;
	logic signed [11:0]   dv;
	logic signed [9:0]    dt;
	logic signed [23:0]   pp;
	logic signed [23:0]   vv;
	logic signed [19:0]   tt;
	logic [21:0]          sqp_s1;
	logic [21:0]          sqv_s1;
	logic [17:0]          sqt_s1;
	logic [DIST_W-1:0]    dist_s2;

	logic [WGT_W+15:0]    prod_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;

	logic [NUM_W-1:0]     dvd;
	logic [DEN_W-1:0]     dvs;
	logic [DC_W-1:0]      nbits;
	logic [NUM_W-1:0]     quot;
	logic                 div_busy;

	logic [1:0]           src_q;
	logic                 out_valid_q;
	logic [15:0]          factor_q;
	logic [1:0]           source_q;
	logic [15:0]          res;

	assign wa    = AW'(entry_index);
	assign count = (int'(entries_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entries_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entries_q <= '0;
		else if (cfg_write)
			entries_q <= entries_in_use;
	end

	always_ff @(posedge clk) begin
		if (cmd.write_en && (int'(entry_index) < TABLE_DEPTH))
			mem[wa[IDX_W-1:0]] <= '{process_hundredths, voltage_mv, temp_deg,
				delay_scale};
		rd_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ptr_q <= '0;
		else if (cmd.start_query)
			ptr_q <= '0;
		else if (cmd.ptr_inc)
			ptr_q <= ptr_q + 1'b1;
	end

	assign dp = {qp_q[10], qp_q} - {rd_q.process[10], rd_q.process};
	assign dv = {1'b0, qv_q} - {1'b0, rd_q.voltage};
	assign dt = {qt_q[8], qt_q} - {rd_q.temperature[8], rd_q.temperature};
	assign pp = 24'(dp) * 24'(dp);
	assign vv = 24'(dv) * 24'(dv);
	assign tt = 20'(dt) * 20'(dt);

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			qp_q <= process_hundredths;
			qv_q <= voltage_mv;
			qt_q <= temp_deg;
		end
		if (cmd.sq_en) begin
			sqp_s1 <= pp[21:0];
			sqv_s1 <= vv[21:0];
			sqt_s1 <= tt[17:0];
		end
		if (cmd.sum_en)
			dist_s2 <= DIST_W'(sqp_s1) + DIST_W'(sqv_s1) + DIST_W'(sqt_s1);
		if (cmd.mul_en)
			prod_q <= quot[WGT_W-1:0] * rd_q.factor;
		if (cmd.start_query) begin
			num_q <= '0;
			den_q <= '0;
		end else if (cmd.acc_en) begin
			num_q <= num_q + NUM_W'(prod_q);
			den_q <= den_q + DEN_W'(quot[WGT_W-1:0]);
		end
	end

	assign dvd   = cmd.div_final ? num_q : {1'b1, {(NUM_W-1){1'b0}}};
	assign dvs   = cmd.div_final ? den_q : DEN_W'(dist_s2);
	assign nbits = cmd.div_final ? DC_W'(NUM_W) : DC_W'(WGT_W);

	idi_div #(
		.DVD_W(NUM_W),
		.DVS_W(DEN_W),
		.CNT_W(DC_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dvd),
		.nbits   (nbits),
		.divisor (dvs),
		.quotient(quot),
		.busy    (div_busy)
	);

	always_ff @(posedge clk) begin
		if (cmd.set_src)
			src_q <= cmd.src;
	end

	always_comb begin
		unique case (src_q)
			SRC_EMPTY:              res = UNITY_FACTOR;
			SRC_SINGLE, SRC_EXACT:  res = rd_q.factor;
			SRC_WEIGHTED:           res = (den_q != '0) ? quot[15:0] : UNITY_FACTOR;
			default:                res = UNITY_FACTOR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			factor_q <= res;
			source_q <= src_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign factor_out = factor_q;
	assign source     = source_q;

	assign sts.count_zero = (count == '0);
	assign sts.count_one  = (count == CW'(1));
	assign sts.last_entry = ((CW'(ptr_q) + CW'(1)) == count);
	assign sts.dist_zero  = (dist_s2 == '0);
	assign sts.div_busy   = div_busy;
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule

// ===== hw/rtl/idi_ctrl.sv =====
// sequencer of the interpolator: accepts words, steps through table entries
// depends on idi_pkg and the assertion macro header
`include "inverse_distance_interpolator_unit_assert.svh"
module idi_ctrl import idi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic op,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RD    = 11'b00000000010,
		S_SQ    = 11'b00000000100,
		S_SUM   = 11'b00000001000,
		S_CHK   = 11'b00000010000,
		S_WDIV  = 11'b00000100000,
		S_MUL   = 11'b00001000000,
		S_ACC   = 11'b00010000000,
		S_FDIV  = 11'b00100000000,
		S_FWAIT = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op == OP_WRITE)
					cmd.write_en = 1'b1;
				if (accept && op == OP_QUERY) begin
					cmd.start_query = 1'b1;
					if (sts.count_zero) begin
						cmd.set_src = 1'b1;
						cmd.src     = SRC_EMPTY;
						state_d     = S_DONE;
					end else
						state_d = S_RD;
				end
			end
			S_RD: state_d = S_SQ;
			S_SQ: begin
				if (sts.count_one) begin
					cmd.set_src = 1'b1;
					cmd.src     = SRC_SINGLE;
					state_d     = S_DONE;
				end else begin
					cmd.sq_en = 1'b1;
					state_d   = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				if (sts.dist_zero) begin
					cmd.set_src = 1'b1;
					cmd.src     = SRC_EXACT;
					state_d     = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_WDIV;
				end
			end
			S_WDIV: begin
				if (!sts.div_busy)
					state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_ACC;
			end
			S_ACC: begin
				cmd.acc_en = 1'b1;
				if (sts.last_entry)
					state_d = S_FDIV;
				else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_FDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_final = 1'b1;
				state_d       = S_FWAIT;
			end
			S_FWAIT: begin
				if (!sts.div_busy) begin
					cmd.set_src = 1'b1;
					cmd.src     = SRC_WEIGHTED;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	`IDI_ASSERT_NOW(a_div_start_idle, clk, arst_n, cmd.div_start, !sts.div_busy,
		"divider started while busy")
	`IDI_ASSERT_NXT(a_div_runs, clk, arst_n, cmd.div_start, sts.div_busy,
		"divider did not start")
	`IDI_ASSERT_NOW(a_out_load_free, clk, arst_n, cmd.out_load, sts.out_free,
		"result overwrote a waiting word")
	`IDI_ASSERT_NXT(a_acc_next, clk, arst_n, cmd.ptr_inc, state_q == S_RD,
		"entry step lost")

endmodule

// ===== hw/rtl/inverse_distance_interpolator_unit.sv =====
// top level of the inverse distance interpolator
// depends on idi_pkg, idi_ctrl, idi_datapath and idi_div
//
// channel   handshake              payload
// in        in_valid / in_stall    op, entry_index, process_hundredths, voltage_mv,
//                                  temp_deg, delay_scale
// out       out_valid / out_stall  factor_out, source
// cfg       cfg_valid / cfg_ready  entries_in_use
//
// a write is done in S_IDLE; an empty query goes to S_DONE, a one-entry query via S_RD, S_SQ
// a weighted query runs the shared bit-serial divider once per entry for its weight
// and once for the final divide, and ends early on an exact match
// reset clears the sequencer, entry count and output valid; the table is not cleared
// a result waits in the output register while stalled; the next word is taken meanwhile
module inverse_distance_interpolator_unit import idi_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [3:0]         entry_index,
	input  logic signed [10:0] process_hundredths,
	input  logic [10:0]        voltage_mv,
	input  logic signed [8:0]  temp_deg,
	input  logic [15:0]        delay_scale,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        factor_out,
	output logic [1:0]         source,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         entries_in_use
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	idi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.op      (op),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	idi_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.entry_index       (entry_index),
		.process_hundredths(process_hundredths),
		.voltage_mv        (voltage_mv),
		.temp_deg          (temp_deg),
		.delay_scale       (delay_scale),
		.cfg_write         (cfg_valid && cfg_ready),
		.entries_in_use    (entries_in_use),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.factor_out        (factor_out),
		.source            (source)
	);

endmodule

// ===== verif/testbench.sv =====
// testbench for the inverse distance interpolator: drives table writes, queries and the
// entry count, and checks each result against a cycle-free predictor in a scoreboard class
// depends on idi_pkg and inverse_distance_interpolator_unit
module testbench;
	import idi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] factor;
		logic [1:0]  src;
	} result_t;

	class interp_scoreboard;
		point_t      points[16];
		logic [4:0]  entry_count;
		result_t     pending[$];
		int          errors;

		function new();
			entry_count = 0;
			errors = 0;
			foreach (points[i]) points[i] = '0;
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		function void set_count(logic [4:0] n);
			entry_count = n;
		endfunction

		function void note_word(logic o, logic [3:0] idx, logic signed [10:0] p,
				logic [10:0] v, logic signed [8:0] t, logic [15:0] f);
			int          n;
			longint      dp, dv, dt;
			logic [63:0] sq_dist, w, num, den;
			result_t     r;
			if (o == OP_WRITE) begin
				points[idx].process = p;
				points[idx].voltage = v;
				points[idx].temperature = t;
				points[idx].factor = f;
				return;
			end
			n = (entry_count > 16) ? 16 : entry_count;
			if (n == 0) begin
				r.factor = UNITY_FACTOR;
				r.src = SRC_EMPTY;
			end else if (n == 1) begin
				r.factor = points[0].factor;
				r.src = SRC_SINGLE;
			end else begin
				num = 0;
				den = 0;
				r.src = SRC_WEIGHTED;
				for (int i = 0; i < n; i++) begin
					dp = longint'($signed(points[i].process)) - longint'(p);
					dv = longint'(points[i].voltage) - longint'(v);
					dt = longint'($signed(points[i].temperature)) - longint'(t);
					sq_dist = dp * dp + dv * dv + dt * dt;
					if (sq_dist == 0) begin
						r.src = SRC_EXACT;
						r.factor = points[i].factor;
						break;
					end
					w = (64'd1 << 32) / sq_dist;
					den += w;
					num += w * points[i].factor;
				end
				if (r.src == SRC_WEIGHTED)
					r.factor = (den != 0) ? 16'(num / den) : UNITY_FACTOR;
			end
			pending = {pending, r};
		endfunction

		task check_result(logic [15:0] f, logic [1:0] s);
			result_t r;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result factor %0d source %0d", f, s));
				return;
			end
			r = pending.pop_front();
			if (f !== r.factor)
				report($sformatf("factor %0d, predicted %0d", f, r.factor));
			if (s !== r.src)
				report($sformatf("source %0d, predicted %0d", s, r.src));
		endtask
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic               op = 0;
	logic [3:0]         entry_index = 0;
	logic signed [10:0] process_hundredths = 0;
	logic [10:0]        voltage_mv = 0;
	logic signed [8:0]  temp_deg = 0;
	logic [15:0]        delay_scale = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic [15:0]        factor_out;
	logic [1:0]         source;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [4:0]         entries_in_use = 0;

	interp_scoreboard sb = new();
	bit no_idle = 0;
	bit hold_req = 0;

	inverse_distance_interpolator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .entry_index(entry_index), .process_hundredths(process_hundredths),
		.voltage_mv(voltage_mv), .temp_deg(temp_deg), .delay_scale(delay_scale),
		.out_valid(out_valid), .out_stall(out_stall),
		.factor_out(factor_out), .source(source),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .entries_in_use(entries_in_use)
	);

	always #6 clk = ~clk;

	// result side
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(factor_out, source);
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 3000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < 25);
			end
		end
	end

	task send_word(logic o, logic [3:0] idx, int p, int v, int t, int f);
		while (!no_idle && $urandom_range(99) < 25) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		entry_index <= idx;
		process_hundredths <= 11'(p);
		voltage_mv <= 11'(v);
		temp_deg <= 9'(t);
		delay_scale <= 16'(f);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(o, idx, 11'(p), 11'(v), 9'(t), 16'(f));
	endtask

	task drain(int limit);
		int n;
		n = 0;
		in_valid <= 0;
		while (sb.pending.size() != 0 && n < limit) begin
			@(posedge clk);
			n++;
		end
		repeat (50) @(posedge clk);
	endtask

	task write_count(logic [4:0] n);
		drain(100000);
		cfg_valid <= 1;
		entries_in_use <= n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		sb.set_count(n);
	endtask

	task random_word(int n);
		int k, p, v, t, f, sel;
		k = (n > 16) ? 16 : n;
		sel = $urandom_range(99);
		f = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : 65535)
			: $urandom_range(65535);
		p = $urandom_range(2000) - 1000;
		v = $urandom_range(2000);
		t = $urandom_range(383) - 128;
		if (sel < 35) begin
			send_word(OP_WRITE, 4'($urandom_range(15)), p, v, t, f);
		end else if (sel < 50 && k > 0) begin
			k = $urandom_range(k - 1);
			send_word(OP_QUERY, 4'($urandom), sb.points[k].process, sb.points[k].voltage,
				sb.points[k].temperature, f);
		end else if (sel < 70 && k > 0) begin
			k = $urandom_range(k - 1);
			p = int'($signed(sb.points[k].process)) + int'($urandom_range(6)) - 3;
			v = int'(sb.points[k].voltage) + int'($urandom_range(6)) - 3;
			t = int'($signed(sb.points[k].temperature)) + int'($urandom_range(6)) - 3;
			if (p > 1000) p = 1000;
			if (p < -1000) p = -1000;
			if (v > 2000) v = 2000;
			if (v < 0) v = 0;
			if (t > 255) t = 255;
			if (t < -128) t = -128;
			send_word(OP_QUERY, 4'($urandom), p, v, t, f);
		end else begin
			send_word(OP_QUERY, 4'($urandom), p, v, t, f);
		end
	endtask

	initial begin
		int counts[12] = '{2, 3, 16, 4, 31, 2, 1, 0, 5, 17, 3, 2};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part
		write_count(0);
		send_word(OP_QUERY, 4'd0, 0, 0, 0, 0);
		send_word(OP_WRITE, 4'd0, -1000, 0, -128, 0);
		send_word(OP_WRITE, 4'd1, 1000, 2000, 255, 65535);
		for (int i = 2; i < 16; i++)
			send_word(OP_WRITE, 4'(i), i * 100 - 800, i * 120, i * 20 - 100, i * 4000);
		write_count(1);
		send_word(OP_QUERY, 4'd15, 1000, 2000, 255, 65535);
		write_count(16);
		send_word(OP_QUERY, 4'd0, -300, 600, 0, 0);
		send_word(OP_QUERY, 4'd0, 1000, 2000, 255, 0);
		send_word(OP_QUERY, 4'd0, -1000, 0, -128, 0);
		send_word(OP_QUERY, 4'd0, -999, 1, -127, 0);
		write_count(31);
		send_word(OP_QUERY, 4'd0, 0, 1000, 100, 0);

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			write_count(5'(counts[ph]));
			no_idle = (ph == 3);
			if (ph == 5) hold_req = 1;
			for (int i = 0; i < 52; i++)
				random_word(counts[ph]);
		end
		no_idle = 0;
		drain(200000);
		while (sb.pending.size() != 0) begin
			void'(sb.pending.pop_front());
			sb.report("expected result never arrived");
		end
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#30ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
